// ===== rtl/vsa_pkg.sv =====
package vsa_pkg;

  localparam int CountW = 4;
  localparam int SlotW  = 3;
  localparam int NoteW  = 7;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;

  localparam logic [AddrW-2-1:0] RegVoiceCount = 1'b0;

  typedef enum logic [2:0] {
    CMD_NEXT     = 3'd0,
    CMD_ACTIVATE = 3'd1,
    CMD_FIND     = 3'd2,
    CMD_RELEASE  = 3'd3,
    CMD_READ     = 3'd4
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [2:0]       cmd;
    logic [SlotW-1:0] slot;
    logic [NoteW-1:0] note;
    logic             found;
    logic [SlotW-1:0] slot_out;
    logic [NoteW-1:0] note_out;
    logic             active_out;
  } tok_t;

endpackage

// ===== rtl/voice_slot_allocator_top.sv =====
// round-robin voice slot allocator
//
// command channel: a word (command, slot, note) is taken on a rising edge with
// start high and busy low. busy rises on the next cycle and stays high while
// the word travels down a row of VOICES slot cells; each cell holds one slot's
// active flag and note and acts on the word as it passes.
// the result word appears on slot_out, found, note_out and active_out for one
// cycle with done high once the word has left the last cell, and is taken at
// the edge that ends that cycle. busy is already low in that cycle, so a new
// word can be taken then; no new word is taken while one is in flight.
// the receiver cannot stall; done is a single-cycle strobe.
// the next-slot command reads and advances the head pointer at the accepting
// edge; the head wraps at voice_count.
// apb port: register 0 is voice_count at byte address 0. a write takes the low
// CountW bits of pwdata, clamps them to 1..VOICES, clears every slot and the
// head; write only while idle. reset: voice_count 1, head 0, all slots
// inactive with note 0, nothing in flight.
module voice_slot_allocator_top
  import vsa_pkg::*;
#(
  parameter int VOICES = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       command,
  input  logic [SlotW-1:0] slot,
  input  logic [NoteW-1:0] note,
  output logic             done,
  output logic [SlotW-1:0] slot_out,
  output logic             found,
  output logic [NoteW-1:0] note_out,
  output logic             active_out,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int VoicesW = $clog2(VOICES + 1) + 1;

  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic [CountW-1:0] head;
  logic [CountW-1:0] head_next;
  logic              accept;
  logic              cfg_wr;
  logic [CountW:0]   head_inc;
  tok_t              tok [VOICES+1];
  tok_t              tok_first;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && (paddr[AddrW-1:2] == RegVoiceCount);
  assign pready = 1'b1;
  assign prdata = DataW'(count);

  always_comb begin
    count_next = pwdata[CountW-1:0];
    if (count_next == '0) begin
      count_next = CountW'(1);
    end else if (VoicesW'(count_next) > VoicesW'(VOICES)) begin
      count_next = CountW'(VOICES);
    end
  end

  assign head_inc = {1'b0, head} + (CountW+1)'(1);

  always_comb begin
    head_next = head;
    if (accept && (command == CMD_NEXT)) begin
      if (head_inc >= {1'b0, count}) begin
        head_next = '0;
      end else begin
        head_next = head_inc[CountW-1:0];
      end
    end
  end

  always_comb begin
    tok_first.valid      = 1'b1;
    tok_first.cmd        = command;
    tok_first.slot       = slot;
    tok_first.note       = note;
    tok_first.found      = 1'b0;
    tok_first.slot_out   = slot;
    tok_first.note_out   = '0;
    tok_first.active_out = 1'b0;
    case (command)
      CMD_NEXT: begin
        tok_first.slot_out = head[SlotW-1:0];
      end
      CMD_FIND: begin
        tok_first.slot_out = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CountW'(1);
      head  <= '0;
      busy  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        count <= count_next;
        head  <= '0;
      end else begin
        head <= head_next;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (tok[VOICES-1].valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= accept;
    end
    if (accept) begin
      tok[0].cmd        <= tok_first.cmd;
      tok[0].slot       <= tok_first.slot;
      tok[0].note       <= tok_first.note;
      tok[0].found      <= tok_first.found;
      tok[0].slot_out   <= tok_first.slot_out;
      tok[0].note_out   <= tok_first.note_out;
      tok[0].active_out <= tok_first.active_out;
    end
  end

  for (genvar k = 0; k < VOICES; k++) begin : g_cell
    vsa_cell #(
      .INDEX(k)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .clr    (cfg_wr),
      .count  (count),
      .tok_in (tok[k]),
      .tok_out(tok[k+1])
    );
  end

  assign done       = tok[VOICES].valid;
  assign slot_out   = tok[VOICES].slot_out;
  assign found      = tok[VOICES].found;
  assign note_out   = tok[VOICES].note_out;
  assign active_out = tok[VOICES].active_out;

endmodule

// ===== rtl/vsa_cell.sv =====
module vsa_cell
  import vsa_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic [CountW-1:0] count,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  logic             active;
  logic [NoteW-1:0] note;
  logic             active_next;
  logic [NoteW-1:0] note_next;
  tok_t             tok_next;
  logic             hit;
  logic             in_use;

  assign hit    = (int'(tok_in.slot) == INDEX);
  assign in_use = (int'(count) > INDEX);

  always_comb begin
    active_next = active;
    note_next   = note;
    tok_next    = tok_in;
    if (tok_in.valid) begin
      case (tok_in.cmd)
        CMD_ACTIVATE: begin
          if (hit) begin
            active_next = 1'b1;
            note_next   = tok_in.note;
          end
        end
        CMD_RELEASE: begin
          if (hit) begin
            active_next = 1'b0;
          end
        end
        CMD_READ: begin
          if (hit) begin
            tok_next.note_out   = note;
            tok_next.active_out = active;
          end
        end
        CMD_FIND: begin
          if (!tok_in.found && in_use && active && (note == tok_in.note)) begin
            tok_next.found    = 1'b1;
            tok_next.slot_out = SlotW'(INDEX);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      active <= 1'b0;
      note   <= '0;
    end else begin
      active <= active_next;
      note   <= note_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.cmd        <= tok_next.cmd;
    tok_out.slot       <= tok_next.slot;
    tok_out.note       <= tok_next.note;
    tok_out.found      <= tok_next.found;
    tok_out.slot_out   <= tok_next.slot_out;
    tok_out.note_out   <= tok_next.note_out;
    tok_out.active_out <= tok_next.active_out;
  end

endmodule
